// File: src/bts_pkg.sv
package bts_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_WEIGHT_BITS = 8;

    localparam int STORE_AW = 16;
    localparam int SIZE_W   = 9;
    localparam int PADDR_W  = 4;

    // register byte addresses
    localparam logic [PADDR_W-1:0] REG_WIDTH  = 4'h0;
    localparam logic [PADDR_W-1:0] REG_HEIGHT = 4'h4;
    localparam logic [PADDR_W-1:0] REG_ALPHA  = 4'h8;
    localparam logic [PADDR_W-1:0] REG_TILED  = 4'hC;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        texel_index;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
        logic [7:0]         in_alpha;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic       capture;    // latch axis values computed from the item
        logic       mem_write;  // write loaded texel
        logic       mem_read;   // issue read
        logic [1:0] read_sel;   // which neighbor to read
        logic       take;       // store returned texel
        logic [1:0] take_sel;
        logic       blend;      // blend x pass
        logic       finish;     // blend y pass into output register
    } t_dp_cmd;

endpackage

// File: src/bts_ctrl.sv
module bts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bts_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, n_rd;
    logic [1:0] r_rd_sel, n_rd_sel;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // sequencer: loads write at once; samples take four reads, then two blend passes
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd        = 1'b0;
        n_rd_sel    = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        o_cmd.take     = r_rd;
        o_cmd.take_sel = r_rd_sel;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_opcode == bts_pkg::OP_LOAD) begin
                        o_cmd.mem_write = 1'b1;
                    end else begin
                        n_state = ST_READ;
                        n_cnt   = 2'd0;
                    end
                end
            end
            ST_READ: begin
                o_cmd.mem_read = 1'b1;
                o_cmd.read_sel = r_cnt;
                n_rd           = 1'b1;
                n_rd_sel       = r_cnt;
                n_cnt          = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_BLEND;
            end
            ST_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 2'd0;
            r_rd        <= 1'b0;
            r_rd_sel    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd        <= n_rd;
            r_rd_sel    <= n_rd_sel;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/bts_datapath.sv
module bts_datapath #(
    parameter int MAX_WIDTH   = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bts_pkg::DEF_MAX_HEIGHT,
    parameter int WEIGHT_BITS = bts_pkg::DEF_WEIGHT_BITS
) (
    input  logic                        i_clk,
    input  bts_pkg::t_in_item           i_item,
    input  bts_pkg::t_dp_cmd            i_cmd,
    input  logic [bts_pkg::SIZE_W-1:0]  i_width,
    input  logic [bts_pkg::SIZE_W-1:0]  i_height,
    input  logic                        i_has_alpha,
    input  logic                        i_tiled,
    output bts_pkg::t_out_item          o_item
);

    localparam int SW  = 13;                  // holds sizes up to 8191
    localparam int WB  = WEIGHT_BITS;
    localparam int HB  = 8 + WB;              // one blend result
    localparam int FB  = 8 + 2 * WB;          // both blends
    localparam logic [SW-1:0] MAXW = SW'(MAX_WIDTH);
    localparam logic [SW-1:0] MAXH = SW'(MAX_HEIGHT);

    logic [31:0] mem [0:(1 << bts_pkg::STORE_AW) - 1];
    logic [31:0] r_rdata;

    logic [SW-1:0] w_eff, h_eff;
    logic [16:0]   cu, cv;
    logic [15:0]   ix1, ix2, iy1, iy2;
    logic [WB-1:0] wx, wy;
    logic [15:0]   r_x1, r_x2, r_y1, r_y2, r_w;
    logic [WB-1:0] r_wx, r_wy;
    logic [31:0]   r_t [0:3];
    logic [HB-1:0] r_top [0:3];
    logic [HB-1:0] r_bot [0:3];
    logic [15:0]   rd_col, rd_row;
    logic [15:0]   rd_addr;

    function automatic logic [SW-1:0] eff(input logic [bts_pkg::SIZE_W-1:0] v,
                                          input logic [SW-1:0] mx);
        logic [SW-1:0] e;
        e = SW'(v);
        if (e == '0) e = SW'(1);
        if (e > mx) e = mx;
        return e;
    endfunction

    function automatic logic [16:0] fixc(input logic [31:0] c, input logic t);
        logic [16:0] r;
        if (t) r = {1'b0, c[15:0]};
        else if (c[31]) r = '0;
        else if (c > 32'h10000) r = 17'h10000;
        else r = c[16:0];
        return r;
    endfunction

    // neighbor pair and weight along one axis
    task automatic axis(input logic [16:0] c, input logic [SW-1:0] sz, input logic t,
                        output logic [15:0] lo, output logic [15:0] hi,
                        output logic [WB-1:0] w);
        logic [31:0] pos;
        logic signed [SW+1:0] a, b, s;
        pos = 32'(c) * 32'(sz) + 32'h8000;
        s = (SW+2)'(sz);
        a = (SW+2)'(pos[31:16]) - (SW+2)'(1);
        if (a < 0) a = t ? a + s : '0;
        b = a + (SW+2)'(1);
        if (b >= s) b = t ? b - s : s - (SW+2)'(1);
        lo = 16'(a);
        hi = 16'(b);
        w  = pos[15:16-WB];
    endtask

    always_comb begin
        w_eff = eff(i_width, MAXW);
        h_eff = eff(i_height, MAXH);
        cu = fixc(i_item.coord_u, i_tiled);
        cv = fixc(i_item.coord_v, i_tiled);
        axis(cu, w_eff, i_tiled, ix1, ix2, wx);
        axis(cv, h_eff, i_tiled, iy1, iy2, wy);
    end

    // neighbor address for this read
    always_comb begin
        rd_col  = i_cmd.read_sel[0] ? r_x2 : r_x1;
        rd_row  = i_cmd.read_sel[1] ? r_y2 : r_y1;
        rd_addr = 16'(rd_row * r_w + rd_col);
    end

    // single-port texel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            mem[i_item.texel_index] <= {i_item.in_alpha, i_item.in_blue,
                                        i_item.in_green, i_item.in_red};
        end else if (i_cmd.mem_read) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // latch axis results at capture, store returned texels at take
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x1 <= ix1;
            r_x2 <= ix2;
            r_y1 <= iy1;
            r_y2 <= iy2;
            r_w  <= 16'(w_eff);
            r_wx <= wx;
            r_wy <= wy;
        end
        if (i_cmd.take) begin
            r_t[i_cmd.take_sel] <= i_has_alpha ? r_rdata : (r_rdata | 32'hFF00_0000);
        end
    end

    // x blend per channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.blend) begin
            for (int ch = 0; ch < 4; ch++) begin
                r_top[ch] <= HB'(r_t[0][ch*8 +: 8] * ((WB+1)'(1 << WB) - r_wx))
                           + HB'(r_t[1][ch*8 +: 8] * r_wx);
                r_bot[ch] <= HB'(r_t[2][ch*8 +: 8] * ((WB+1)'(1 << WB) - r_wx))
                           + HB'(r_t[3][ch*8 +: 8] * r_wx);
            end
        end
    end

    // y blend and rounding
    logic [FB-1:0] fin [0:3];
    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            fin[ch] = FB'(r_top[ch] * ((WB+1)'(1 << WB) - r_wy)) + FB'(r_bot[ch] * r_wy)
                    + FB'(1 << (2*WB-1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_item.out_red   <= fin[0][2*WB +: 8];
            o_item.out_green <= fin[1][2*WB +: 8];
            o_item.out_blue  <= fin[2][2*WB +: 8];
            o_item.out_alpha <= fin[3][2*WB +: 8];
        end
    end

endmodule

// File: src/bilinear_texture_sampler.sv
// bilinear texture sampler
// input channel (i_in_valid / o_in_stall, payload i_in_item) carries load
// items, which write one RGBA texel into the 64K-entry store, and sample
// items with 16.16 coordinates. a transfer happens when valid is high and
// stall is low.
// a load gives no result and does not hold the input.
// a sample reads four texels from the single-port store, one per cycle,
// then blends along x and along y and writes the result to the output
// register once that register is free. a new item is taken only after the
// sample finishes; loads run at one per cycle.
// output channel (o_out_valid / i_out_stall, payload o_out_item) holds its
// result while stalled; a finished sample waits only for the output register.
// apb port: width at 0x0, height 0x4, has_alpha 0x8, tiled 0xc.
// reset clears control and registers (width 1, height 1, flags 0); the
// texel store is undefined until written, no clearing pass.
module bilinear_texture_sampler #(
    parameter int MAX_WIDTH   = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bts_pkg::DEF_MAX_HEIGHT,
    parameter int WEIGHT_BITS = bts_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bts_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bts_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bts_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [bts_pkg::SIZE_W-1:0] r_width, r_height;
    logic r_has_alpha, r_tiled;
    bts_pkg::t_dp_cmd cmd;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= bts_pkg::SIZE_W'(1);
            r_height    <= bts_pkg::SIZE_W'(1);
            r_has_alpha <= 1'b0;
            r_tiled     <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                bts_pkg::REG_WIDTH:  r_width     <= pwdata[bts_pkg::SIZE_W-1:0];
                bts_pkg::REG_HEIGHT: r_height    <= pwdata[bts_pkg::SIZE_W-1:0];
                bts_pkg::REG_ALPHA:  r_has_alpha <= pwdata[0];
                bts_pkg::REG_TILED:  r_tiled     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr)
            bts_pkg::REG_WIDTH:  prdata = 32'(r_width);
            bts_pkg::REG_HEIGHT: prdata = 32'(r_height);
            bts_pkg::REG_ALPHA:  prdata = 32'(r_has_alpha);
            bts_pkg::REG_TILED:  prdata = 32'(r_tiled);
            default:             prdata = '0;
        endcase
    end

    bts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_in_item.opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    bts_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_has_alpha (r_has_alpha),
        .i_tiled     (r_tiled),
        .o_item      (o_out_item)
    );

endmodule

// File: sim/tb_bilinear_texture_sampler.sv
module tb_bilinear_texture_sampler;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 16;

    // predictor and store of expected filtered texels
    class texel_scoreboard;
        bit [31:0]  texels [65536];
        bit [8:0]   width_reg = 9'd1;
        bit [8:0]   height_reg = 9'd1;
        bit         alpha_reg = 1'b0;
        bit         tiled_reg = 1'b0;
        bts_pkg::t_out_item expected_texels [$];
        int         errors = 0;
        int         loads = 0;
        int         samples = 0;

        function int eff_size(bit [8:0] v, int maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void write_reg(logic [bts_pkg::PADDR_W-1:0] addr, bit [31:0] value);
            case (addr)
                bts_pkg::REG_WIDTH:  width_reg = value[8:0];
                bts_pkg::REG_HEIGHT: height_reg = value[8:0];
                bts_pkg::REG_ALPHA:  alpha_reg = value[0];
                bts_pkg::REG_TILED:  tiled_reg = value[0];
                default: ;
            endcase
        endfunction

        // neighbors and weight along one axis
        function void axis(bit [31:0] raw, int size, output int lo, output int hi,
                           output int wgt);
            bit [31:0] c;
            bit [31:0] pos;
            int        a;
            int        b;
            if (tiled_reg) c = {16'h0, raw[15:0]};
            else if (raw[31]) c = 0;
            else if (raw > 32'h10000) c = 32'h10000;
            else c = raw;
            pos = c * size + 32'h8000;
            a = int'(pos >> 16) - 1;
            if (a < 0) a = tiled_reg ? a + size : 0;
            b = a + 1;
            if (b >= size) b = tiled_reg ? b - size : size - 1;
            lo = a;
            hi = b;
            wgt = pos[15:8];
        endfunction

        function bit [31:0] fetch(int col, int row, int w);
            bit [31:0] t;
            t = texels[(row * w + col) & 16'hFFFF];
            if (!alpha_reg) t[31:24] = 8'hFF;
            return t;
        endfunction

        function void note(bts_pkg::t_in_item it);
            int        w, h, x1, x2, y1, y2, wx, wy;
            bit [31:0] t11, t12, t21, t22;
            longint    top, bot, v;
            bit [7:0]  ch [4];
            if (it.opcode == bts_pkg::OP_LOAD) begin
                texels[it.texel_index] = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
                loads++;
                return;
            end
            w = eff_size(width_reg, bts_pkg::DEF_MAX_WIDTH);
            h = eff_size(height_reg, bts_pkg::DEF_MAX_HEIGHT);
            axis(it.coord_u, w, x1, x2, wx);
            axis(it.coord_v, h, y1, y2, wy);
            t11 = fetch(x1, y1, w);
            t12 = fetch(x2, y1, w);
            t21 = fetch(x1, y2, w);
            t22 = fetch(x2, y2, w);
            for (int k = 0; k < 4; k++) begin
                top = t11[k*8 +: 8] * (256 - wx) + t12[k*8 +: 8] * wx;
                bot = t21[k*8 +: 8] * (256 - wx) + t22[k*8 +: 8] * wx;
                v = (top * (256 - wy) + bot * wy + 32768) >> 16;
                ch[k] = v[7:0];
            end
            expected_texels.push_back('{out_red: ch[0], out_green: ch[1],
                                        out_blue: ch[2], out_alpha: ch[3]});
            samples++;
        endfunction

        function void cmp(string name, bit [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(bts_pkg::t_out_item got);
            bts_pkg::t_out_item e;
            if (expected_texels.size() == 0) begin
                $error("unexpected result transfer: %h", got);
                errors++;
                return;
            end
            e = expected_texels.pop_front();
            cmp("out_red", e.out_red, got.out_red);
            cmp("out_green", e.out_green, got.out_green);
            cmp("out_blue", e.out_blue, got.out_blue);
            cmp("out_alpha", e.out_alpha, got.out_alpha);
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    bts_pkg::t_in_item            i_in_item = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    bts_pkg::t_out_item           o_out_item;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [bts_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    texel_scoreboard sb = new();
    int cycles = 0;
    int holds_req = 0;
    int holds_done = 0;

    bilinear_texture_sampler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // input and result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note(i_in_item);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out_item);
    end

    // receiver stall pattern, with requested long hold-offs
    initial begin
        int run;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (holds_req > holds_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
                run = 0;
            end else if (run == 0) begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 4);
            end else begin
                run--;
            end
        end
    end

    task automatic apb_write(logic [bts_pkg::PADDR_W-1:0] addr, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(addr, value);
    endtask

    task automatic send(bts_pkg::t_in_item it);
        int gap;
        i_in_item <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            9:             gap = $urandom_range(10, 30);
            default:       gap = $urandom_range(1, 3);
        endcase
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_texels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load(int idx, bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a);
        bts_pkg::t_in_item it;
        it = '0;
        it.opcode = bts_pkg::OP_LOAD;
        it.texel_index = idx[15:0];
        it.in_red = r;
        it.in_green = g;
        it.in_blue = b;
        it.in_alpha = a;
        it.coord_u = $urandom();
        it.coord_v = $urandom();
        send(it);
    endtask

    task automatic sample(bit [31:0] u, bit [31:0] v);
        bts_pkg::t_in_item it;
        it = '0;
        it.opcode = bts_pkg::OP_SAMPLE;
        it.texel_index = 16'($urandom());
        it.in_red = 8'($urandom());
        it.coord_u = u;
        it.coord_v = v;
        send(it);
    endtask

    function automatic bit [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2, 3:    return $urandom_range(0, 32'h40000) - 32'h20000;
            default: return $urandom_range(0, 32'h10000);
        endcase
    endfunction

    // fills every texel of the current image
    task automatic load_image();
        int w, h;
        w = sb.eff_size(sb.width_reg, bts_pkg::DEF_MAX_WIDTH);
        h = sb.eff_size(sb.height_reg, bts_pkg::DEF_MAX_HEIGHT);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                load(r * w + c, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                     8'($urandom()));
    endtask

    task automatic random_items(int count, bit with_hold);
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 3) holds_req++;
            if ($urandom_range(0, 4) == 0)
                load($urandom_range(0, 65535), 8'($urandom()), 8'($urandom()),
                     8'($urandom()), 8'($urandom()));
            else
                sample(rand_coord(), rand_coord());
        end
    endtask

    initial begin
        int pw [6];
        int ph [6];
        bit pa [6];
        bit pt [6];

        pw = '{256, 0, 5, 12, 7, 4};
        ph = '{1, 300, 3, 10, 9, 4};
        pa = '{1, 0, 1, 0, 1, 0};
        pt = '{1, 1, 0, 1, 1, 0};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, extreme fields and coordinates
        load(0, 8'hFF, 8'h00, 8'hFF, 8'h00);
        load(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        load(16'hAAAA, 8'h55, 8'hAA, 8'h01, 8'h80);
        sample(32'h0, 32'h0);
        sample(32'h8000_0000, 32'h7FFF_FFFF);
        sample(32'h7FFF_FFFF, 32'h8000_0000);
        sample(32'h0001_0000, 32'h0001_0000);
        sample(32'hFFFF_FFFF, 32'h0000_8000);
        sample(32'h0001_8000, 32'hFFFF_8000);
        load(0, 8'h00, 8'hFF, 8'h00, 8'hFF);
        sample(32'h0000_4000, 32'h0000_C000);
        drain();

        // one phase per image setting
        for (int p = 0; p < 6; p++) begin
            apb_write(bts_pkg::REG_WIDTH, pw[p]);
            apb_write(bts_pkg::REG_HEIGHT, ph[p]);
            apb_write(bts_pkg::REG_ALPHA, 32'(pa[p]));
            apb_write(bts_pkg::REG_TILED, 32'(pt[p]));
            load_image();
            sample(32'h8000_0000, 32'h7FFF_FFFF);
            sample(32'h0001_0000, 32'h0);
            random_items(70, p == 3);
            drain();
        end

        $display("covered %0d loads and %0d samples over 7 image settings,",
                 sb.loads, sb.samples);
        $display("with clamp and wrap, forced and stored alpha, %0d long output hold",
                 holds_done);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
src/bts_pkg.sv
src/bts_ctrl.sv
src/bts_datapath.sv
src/bilinear_texture_sampler.sv
sim/tb_bilinear_texture_sampler.sv
